FILE: sv/rtp_reorder_jitter_buffer_top_defines.svh
// assertion macros shared by the checker
`ifndef RTP_REORDER_JITTER_BUFFER_TOP_DEFINES_SVH
`define RTP_REORDER_JITTER_BUFFER_TOP_DEFINES_SVH

// condition holds in the same cycle
`define RTPRJB_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rtprjb assertion failed");

// condition holds in the next cycle
`define RTPRJB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rtprjb assertion failed");

`endif

FILE: sv/rtprjb_pkg.sv
`timescale 1ns / 1ps
package rtprjb_pkg;

  // slot count, a power of two
  localparam int SLOTS  = 256;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SEQ_W  = 16;
  localparam int HND_W  = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [CFG_W-1:0] MAX_BUF_RESET = CFG_W'(400);

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [HND_W-1:0]  handle;
    logic [SEQ_W-1:0]  seq;
  } slot_entry_t;

endpackage

FILE: sv/rtprjb_slot_ram.sv
`timescale 1ns / 1ps
module rtprjb_slot_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rtp_reorder_jitter_buffer_top.sv
`timescale 1ns / 1ps
// insert: ST_EXEC, then ST_EMIT raises out_tvalid; in_tready stays low until back in ST_IDLE
// pop with the expected packet stored: ST_EXEC, ST_RD_E, then ST_EMIT
// pop that needs the front (after an expected-slot miss too): ST_SCAN, ST_DECIDE, ST_EMIT;
//   ST_SCAN reads every slot, one entry per cycle, through the slot memory read port
// reset is synchronous, active low: valid bits clear together, no clearing pass,
//   max_buffering_ms returns to 400
module rtp_reorder_jitter_buffer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seq_num[15:0], handle[31:16], now_ms[63:32]
  input  logic [rtprjb_pkg::IN_DATA_W-1:0] in_tdata,
  // operation[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // accepted[0], out_valid[1], out_seq[17:2], out_handle[33:18],
  // skipped_loss[34], available[35], zero[39:36]
  output logic [rtprjb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtprjb_pkg::CFG_W-1:0]     cfg_data
);
  import rtprjb_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RD_E   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  typedef struct packed {
    logic              skipped;
    logic [HND_W-1:0]  handle;
    logic [SEQ_W-1:0]  seq;
    logic              dlv;
    logic              accepted;
  } result_t;

  function automatic logic seq_behind(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  max_buf_r, max_buf_nxt;
  logic [SLOTS-1:0]  slot_valid_r, slot_valid_nxt;
  logic              first_mode_r, first_mode_nxt;
  logic [SEQ_W-1:0]  expected_r, expected_nxt;
  logic [SEQ_W-1:0]  earliest_r, earliest_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;

  logic              op_r, op_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [HND_W-1:0]  hnd_r, hnd_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SEQ_W:0]    best_off_r, best_off_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  slot_entry_t       best_ent_r, best_ent_nxt;
  result_t           res_r, res_nxt;
  result_t           out_res_r, out_res_nxt;
  logic              out_avail_r, out_avail_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_entry_t       ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  slot_entry_t       ram_rdata;

  logic [IDX_W-1:0]  ins_idx;
  logic              ins_ok;
  logic [SEQ_W-1:0]  scan_off;
  logic [TIME_W-1:0] waited;

  rtprjb_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(slot_entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_avail_r, out_res_r.skipped, out_res_r.handle,
                       out_res_r.seq, out_res_r.dlv, out_res_r.accepted};

  assign ins_idx  = seq_r[IDX_W-1:0];
  assign ins_ok   = first_mode_r || !seq_behind(seq_r, expected_r);
  assign scan_off = ram_rdata.seq - earliest_r;
  assign waited   = now_r - best_ent_r.arrival;

  always_comb begin
    state_nxt      = state_r;
    max_buf_nxt    = max_buf_r;
    slot_valid_nxt = slot_valid_r;
    first_mode_nxt = first_mode_r;
    expected_nxt   = expected_r;
    earliest_nxt   = earliest_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cmp_vld_nxt    = 1'b0;
    op_nxt         = op_r;
    seq_nxt        = seq_r;
    hnd_nxt        = hnd_r;
    now_nxt        = now_r;
    scan_cnt_nxt   = scan_cnt_r;
    best_off_nxt   = best_off_r;
    best_idx_nxt   = best_idx_r;
    best_ent_nxt   = best_ent_r;
    res_nxt        = res_r;
    out_res_nxt    = out_res_r;
    out_avail_nxt  = out_avail_r;
    ram_we         = 1'b0;
    ram_waddr      = ins_idx;
    ram_wdata      = '{arrival: now_r, handle: hnd_r, seq: seq_r};
    ram_raddr      = scan_cnt_r[IDX_W-1:0];

    if (cfg_valid) begin
      max_buf_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          seq_nxt   = in_tdata[15:0];
          hnd_nxt   = in_tdata[31:16];
          now_nxt   = in_tdata[63:32];
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_nxt = '0;
        if (op_r == OP_INSERT) begin
          res_nxt.accepted = ins_ok;
          if (ins_ok && !slot_valid_r[ins_idx]) begin
            if (fill_r == '0 || seq_behind(seq_r, earliest_r)) begin
              earliest_nxt = seq_r;
            end
            slot_valid_nxt[ins_idx] = 1'b1;
            ram_we   = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
          state_nxt = ST_EMIT;
        end else if (fill_r == '0) begin
          state_nxt = ST_EMIT;
        end else if (first_mode_r) begin
          scan_cnt_nxt = '0;
          best_off_nxt = {1'b1, {SEQ_W{1'b0}}};
          state_nxt    = ST_SCAN;
        end else begin
          ram_raddr = expected_r[IDX_W-1:0];
          state_nxt = ST_RD_E;
        end
      end
      ST_RD_E: begin
        if (rd_vld_r && ram_rdata.seq == expected_r) begin
          slot_valid_nxt[cmp_idx_r] = 1'b0;
          fill_nxt       = fill_r - CNT_W'(1);
          first_mode_nxt = 1'b0;
          expected_nxt   = ram_rdata.seq + SEQ_W'(1);
          earliest_nxt   = ram_rdata.seq + SEQ_W'(1);
          res_nxt.dlv    = 1'b1;
          res_nxt.seq    = ram_rdata.seq;
          res_nxt.handle = ram_rdata.handle;
          state_nxt      = ST_EMIT;
        end else begin
          scan_cnt_nxt = '0;
          best_off_nxt = {1'b1, {SEQ_W{1'b0}}};
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r != CNT_W'(SLOTS)) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
          cmp_vld_nxt  = 1'b1;
        end
        if (cmp_vld_r) begin
          if (rd_vld_r && {1'b0, scan_off} < best_off_r) begin
            best_off_nxt = {1'b0, scan_off};
            best_idx_nxt = cmp_idx_r;
            best_ent_nxt = ram_rdata;
          end
          if (scan_cnt_r == CNT_W'(SLOTS)) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (first_mode_r || waited > {{(TIME_W-CFG_W){1'b0}}, (max_buf_r >> 1)}) begin
          slot_valid_nxt[best_idx_r] = 1'b0;
          fill_nxt        = fill_r - CNT_W'(1);
          first_mode_nxt  = 1'b0;
          expected_nxt    = best_ent_r.seq + SEQ_W'(1);
          earliest_nxt    = best_ent_r.seq + SEQ_W'(1);
          res_nxt.dlv     = 1'b1;
          res_nxt.seq     = best_ent_r.seq;
          res_nxt.handle  = best_ent_r.handle;
          res_nxt.skipped = !first_mode_r;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_avail_nxt = (fill_r != '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    cmp_idx_nxt = ram_raddr;
    rd_vld_nxt  = slot_valid_r[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_buf_r    <= MAX_BUF_RESET;
      slot_valid_r <= '0;
      first_mode_r <= 1'b1;
      expected_r   <= '0;
      earliest_r   <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      max_buf_r    <= max_buf_nxt;
      slot_valid_r <= slot_valid_nxt;
      first_mode_r <= first_mode_nxt;
      expected_r   <= expected_nxt;
      earliest_r   <= earliest_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    seq_r       <= seq_nxt;
    hnd_r       <= hnd_nxt;
    now_r       <= now_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    rd_vld_r    <= rd_vld_nxt;
    best_off_r  <= best_off_nxt;
    best_idx_r  <= best_idx_nxt;
    best_ent_r  <= best_ent_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    out_avail_r <= out_avail_nxt;
  end

endmodule

FILE: sv/rtprjb_checker.sv
`timescale 1ns / 1ps
`include "rtp_reorder_jitter_buffer_top_defines.svh"
module rtprjb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rtprjb_pkg::OUT_DATA_W-1:0] out_tdata
);

  `RTPRJB_ASSERT_NEXT(a_out_hold, (out_tvalid && !out_tready), (out_tvalid && $stable(out_tdata)))
  `RTPRJB_ASSERT_NEXT(a_one_in_flight, (in_tvalid && in_tready), (!in_tready))
  `RTPRJB_ASSERT_NEXT(a_out_gap, (out_tvalid && out_tready), (!out_tvalid))
  `RTPRJB_ASSERT_NOW(a_no_dlv_zero, (out_tvalid && !out_tdata[1]), (out_tdata[34:2] == 33'd0))

endmodule

bind rtp_reorder_jitter_buffer_top rtprjb_checker u_rtprjb_checker (.*);
